@@ sv/ale_pkg.sv @@
// shared types and constants for the array list engine
// no dependencies; imported by the engine top level, its checker and the testbench

package ale_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 5;
	localparam int DATA_W   = 32;

	localparam logic [1:0] ACT_INSERT   = 2'd0;
	localparam logic [1:0] ACT_DELETE   = 2'd1;
	localparam logic [1:0] ACT_LOCATE   = 2'd2;
	localparam logic [1:0] ACT_RETRIEVE = 2'd3;

	localparam logic signed [DATA_W-1:0] RETRIEVE_FAIL = -32'sd1000000;

	typedef struct packed {
		logic [1:0]               action;
		logic [4:0]               slot;
		logic signed [DATA_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         found_slot;
		logic [CNT_W-1:0]         entry_count;
	} rsp_t;

endpackage

@@ sv/ale_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module ale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/array_list_engine_unit.sv @@
// array list engine top level: fsm, shift walker and list storage
// depends on ale_pkg and ale_ram

// An ordered list of up to CAPACITY signed 32-bit entries kept in one ram.
// A request is taken when start is high and busy is low; its single result
// appears with done high for exactly one cycle and must be taken then, as
// the block cannot be held off. busy is high from the cycle after a request
// until the cycle its result shows. The ram moves one entry per cycle
// through a read-then-write walk. A request that moves or scans nothing
// (a rejected one, an insert at the end, a delete of the last entry, a
// locate on an empty list) runs no walk; an insert or a delete walks the
// entries that it moves, a locate walks until its match or through the
// whole list when nothing matches, and a successful retrieve reads one
// entry. The next request can be taken at the edge that takes the result.

module array_list_engine_unit import ale_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                     state_q;
	logic [1:0]               act_q;
	logic [4:0]               slot_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     ok_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         idx_q;
	logic [CNT_W-1:0]         left_q;
	logic                     up_q;
	logic                     rd_vld_s1;
	logic [CNT_W-1:0]         rd_addr_s1;
	logic signed [DATA_W-1:0] data_q;
	logic                     done_q;
	rsp_t                     rsp_q;

	logic              accept;
	logic              req_ok;
	logic [CNT_W-1:0]  init_left;
	logic [CNT_W-1:0]  init_idx;
	logic              init_up;
	logic              match;
	logic              drained;
	logic              finish;
	logic              issue;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] rdata;
	logic [CNT_W-1:0]  next_cnt;
	rsp_t              rsp_d;

	assign accept = start && !busy;
	assign busy   = (state_q == ST_RUN);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// request checks and walk setup
	always_comb begin
		req_ok    = 1'b0;
		init_left = '0;
		init_idx  = '0;
		init_up   = 1'b1;
		case (req.action)
			ACT_INSERT: begin
				req_ok = (cnt_q < CNT_W'(CAPACITY)) && (req.slot <= cnt_q);
				if (req_ok) begin
					init_left = cnt_q - req.slot;
				end
				init_idx = cnt_q - CNT_W'(1);
				init_up  = 1'b0;
			end
			ACT_DELETE: begin
				req_ok = (req.slot < cnt_q);
				if (req_ok) begin
					init_left = cnt_q - req.slot - CNT_W'(1);
				end
				init_idx = req.slot + CNT_W'(1);
			end
			ACT_LOCATE: begin
				req_ok    = 1'b1;
				init_left = cnt_q;
			end
			default: begin
				req_ok = (req.slot < cnt_q);
				if (req_ok) begin
					init_left = CNT_W'(1);
				end
				init_idx = req.slot;
			end
		endcase
	end

	assign match   = (act_q == ACT_LOCATE) && rd_vld_s1 && ($signed(rdata) == value_q);
	assign drained = (left_q == '0) && !rd_vld_s1;
	assign finish  = (state_q == ST_RUN) && (drained || match);
	assign issue   = (state_q == ST_RUN) && (left_q != '0) && !finish;

	// write-back of shifted entries, then the new entry for an insert
	always_comb begin
		we    = 1'b0;
		waddr = slot_q[IDX_W-1:0];
		wdata = value_q;
		if (state_q == ST_RUN) begin
			if (rd_vld_s1) begin
				wdata = rdata;
				if (act_q == ACT_INSERT) begin
					we    = 1'b1;
					waddr = IDX_W'(rd_addr_s1 + CNT_W'(1));
				end else if (act_q == ACT_DELETE) begin
					we    = 1'b1;
					waddr = IDX_W'(rd_addr_s1 - CNT_W'(1));
				end
			end else if (drained && ok_q && (act_q == ACT_INSERT)) begin
				we = 1'b1;
			end
		end
	end

	ale_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		next_cnt = cnt_q;
		if (ok_q && (act_q == ACT_INSERT)) begin
			next_cnt = cnt_q + CNT_W'(1);
		end else if (ok_q && (act_q == ACT_DELETE)) begin
			next_cnt = cnt_q - CNT_W'(1);
		end
		rsp_d.ok          = ok_q;
		rsp_d.read_value  = '0;
		rsp_d.found_slot  = '0;
		rsp_d.entry_count = next_cnt;
		if (act_q == ACT_RETRIEVE) begin
			rsp_d.read_value = ok_q ? data_q : RETRIEVE_FAIL;
		end
		if (act_q == ACT_LOCATE) begin
			rsp_d.found_slot = match ? rd_addr_s1 : cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (finish) begin
						state_q <= ST_IDLE;
						cnt_q   <= next_cnt;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= req.action;
			slot_q  <= req.slot;
			value_q <= req.item_value;
			ok_q    <= req_ok;
			left_q  <= init_left;
			idx_q   <= init_idx;
			up_q    <= init_up;
		end else if (issue) begin
			left_q <= left_q - CNT_W'(1);
			idx_q  <= up_q ? (idx_q + CNT_W'(1)) : (idx_q - CNT_W'(1));
		end
		if (issue) begin
			rd_addr_s1 <= idx_q;
		end
		if (rd_vld_s1) begin
			data_q <= $signed(rdata);
		end
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

@@ sv/ale_chk.sv @@
// port-level checker for the array list engine, bound to the top level
// depends on ale_pkg

module ale_chk import ale_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// a transfer always starts a busy period
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// results only close a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside the end of a busy period");

	// the result strobe is never raised back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.entry_count <= CNT_W'(CAPACITY)) && (rsp.found_slot <= rsp.entry_count))
		else $error("entry count or found slot out of range");

endmodule

bind array_list_engine_unit ale_chk u_ale_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

@@ bench/tb_top.sv @@
// testbench for the array list engine: directed and random list requests,
// each result checked against a shadow copy of the list kept in a small class
// depends on ale_pkg and array_list_engine_unit

module tb_top;
	import ale_pkg::*;

	localparam int WATCHDOG_LIMIT = 400;
	localparam int TAIL_CYCLES    = 40;
	localparam int RANDOM_ITEMS   = 1700;

	localparam int MODE_FILL     = 0;
	localparam int MODE_DRAIN    = 1;
	localparam int MODE_BALANCED = 2;

	class list_shadow;
		logic signed [DATA_W-1:0] entries [CAPACITY];
		int unsigned count;
		rsp_t awaited [$];
		int mismatches;

		function new();
			count = 0;
			mismatches = 0;
		endfunction

		function rsp_t apply_request(req_t r);
			rsp_t o;
			int unsigned i;
			int unsigned hit;
			o = '0;
			case (r.action)
				ACT_INSERT: begin
					if (count < CAPACITY && r.slot <= count) begin
						for (i = count; i > r.slot; i--)
							entries[i] = entries[i-1];
						entries[r.slot] = r.item_value;
						count++;
						o.ok = 1'b1;
					end
				end
				ACT_DELETE: begin
					if (r.slot < count) begin
						for (i = r.slot; i + 1 < count; i++)
							entries[i] = entries[i+1];
						count--;
						o.ok = 1'b1;
					end
				end
				ACT_LOCATE: begin
					hit = count;
					for (i = count; i > 0; i--)
						if (entries[i-1] == r.item_value)
							hit = i - 1;
					o.found_slot = CNT_W'(hit);
					o.ok = 1'b1;
				end
				default: begin
					if (r.slot < count) begin
						o.read_value = entries[r.slot];
						o.ok = 1'b1;
					end else begin
						o.read_value = RETRIEVE_FAIL;
					end
				end
			endcase
			o.entry_count = CNT_W'(count);
			return o;
		endfunction

		function void take_request(req_t r);
			awaited.push_back(apply_request(r));
		endfunction

		function void check_response(rsp_t r);
			rsp_t e;
			if (awaited.size() == 0) begin
				$error("unexpected result: ok %0b read_value %0d found_slot %0d entry_count %0d",
					r.ok, r.read_value, r.found_slot, r.entry_count);
				mismatches++;
				return;
			end
			e = awaited.pop_front();
			if (r.ok !== e.ok) begin
				$error("ok: expected %0b, got %0b", e.ok, r.ok);
				mismatches++;
			end
			if (r.read_value !== e.read_value) begin
				$error("read_value: expected %0d, got %0d", e.read_value, r.read_value);
				mismatches++;
			end
			if (r.found_slot !== e.found_slot) begin
				$error("found_slot: expected %0d, got %0d", e.found_slot, r.found_slot);
				mismatches++;
			end
			if (r.entry_count !== e.entry_count) begin
				$error("entry_count: expected %0d, got %0d", e.entry_count, r.entry_count);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	list_shadow shadow;
	int idle_cycles;

	array_list_engine_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			shadow.check_response(rsp);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// holds the request until the block takes it, then returns at the next falling edge
	task automatic send(input req_t r);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		shadow.take_request(r);
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [1:0] act, input logic [4:0] pos,
		input logic signed [DATA_W-1:0] val);
		req_t r;
		r.action = act;
		r.slot = pos;
		r.item_value = val;
		send(r);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			v = $signed(DATA_W'($urandom_range(0, 7))) - 3;
		else if (roll < 8)
			v = $urandom;
		else if (roll == 8)
			v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		else if (shadow.count > 0)
			v = shadow.entries[$urandom_range(0, shadow.count - 1)];
		else
			v = RETRIEVE_FAIL;
		return v;
	endfunction

	function automatic req_t next_request(int mode);
		req_t r;
		int unsigned roll;
		int unsigned c;
		int unsigned ins_cut;
		int unsigned del_cut;
		int unsigned loc_cut;
		c = shadow.count;
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				ins_cut = 65; del_cut = 80; loc_cut = 90;
			end
			MODE_DRAIN: begin
				ins_cut = 25; del_cut = 65; loc_cut = 82;
			end
			default: begin
				ins_cut = 40; del_cut = 65; loc_cut = 82;
			end
		endcase
		if (roll < ins_cut)
			r.action = ACT_INSERT;
		else if (roll < del_cut)
			r.action = ACT_DELETE;
		else if (roll < loc_cut)
			r.action = ACT_LOCATE;
		else
			r.action = ACT_RETRIEVE;
		// mostly legal positions, with some out-of-range noise
		if ($urandom_range(0, 9) == 0)
			r.slot = 5'($urandom_range(0, 31));
		else if (r.action == ACT_INSERT)
			r.slot = 5'($urandom_range(0, c));
		else if (c > 0)
			r.slot = 5'($urandom_range(0, c - 1));
		else
			r.slot = '0;
		r.item_value = pick_value();
		return r;
	endfunction

	initial begin
		int sent;
		int seg_left;
		int burst_left;
		int gap;
		int mode;
		bit first_seg;

		shadow = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list corners
		send_fields(ACT_RETRIEVE, 5'd0, 32'sd0);
		send_fields(ACT_DELETE, 5'd0, 32'sd0);
		send_fields(ACT_LOCATE, 5'd0, 32'sd5);
		send_fields(ACT_INSERT, 5'd1, 32'sd3);
		send_fields(ACT_INSERT, 5'd31, 32'sd9);
		// build a short list with extreme values and a duplicate
		send_fields(ACT_INSERT, 5'd0, 32'sh7fffffff);
		send_fields(ACT_INSERT, 5'd0, 32'sh80000000);
		send_fields(ACT_INSERT, 5'd2, -32'sd1);
		send_fields(ACT_INSERT, 5'd1, 32'sd0);
		send_fields(ACT_INSERT, 5'd1, -32'sd1);
		send_fields(ACT_LOCATE, 5'd0, -32'sd1);
		send_fields(ACT_LOCATE, 5'd31, 32'sd42);
		send_fields(ACT_RETRIEVE, 5'd4, 32'sd0);
		send_fields(ACT_RETRIEVE, 5'd5, 32'sd0);
		send_fields(ACT_RETRIEVE, 5'd31, 32'sd0);
		send_fields(ACT_DELETE, 5'd5, 32'sd0);
		send_fields(ACT_DELETE, 5'd31, 32'sd0);
		send_fields(ACT_DELETE, 5'd0, 32'sd0);
		send_fields(ACT_DELETE, 5'd3, 32'sd0);
		send_fields(ACT_INSERT, 5'd3, RETRIEVE_FAIL);
		send_fields(ACT_RETRIEVE, 5'd3, 32'sd0);

		sent = 0;
		seg_left = 0;
		burst_left = 0;
		mode = MODE_FILL;
		first_seg = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			if (seg_left == 0) begin
				if (!first_seg && ($urandom_range(0, 2) == 0 || sent < 150)) begin
					start <= 1'b0;
					while (shadow.awaited.size() != 0)
						@(negedge clk);
					@(negedge clk);
				end
				first_seg = 1'b0;
				mode = $urandom_range(MODE_FILL, MODE_BALANCED);
				seg_left = $urandom_range(40, 120);
			end
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
					: $urandom_range(1, 12);
			end
			send(next_request(mode));
			sent++;
			seg_left--;
			burst_left--;
		end

		start <= 1'b0;
		while (shadow.awaited.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (shadow.mismatches == 0 && shadow.awaited.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
